FILE: design/sfc_pkg.sv
package sfc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF  = 32;
  localparam int unsigned SYMBOL_WIDTH_DEF = 16;
  localparam int unsigned SYM_BITS         = 16;
  localparam int unsigned DB_BITS          = 4;
  localparam int unsigned CNT_BITS         = 7;
  localparam int unsigned ID_BITS          = 17;

  localparam logic [CNT_BITS-1:0] COUNT_MAX     = 7'd127;
  localparam logic [DB_BITS-1:0]  DATA_BITS_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_START = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_PARITY   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE   = 2'd0;
  localparam step_t STEP_CHECK  = 2'd1;
  localparam step_t STEP_DATA   = 2'd2;
  localparam step_t STEP_STATUS = 2'd3;

  typedef enum logic [1:0] {
    COND_STOP = 2'd0,
    COND_SKIP = 2'd1,
    COND_LAST = 2'd2,
    COND_FREE = 2'd3
  } cond_e;

  typedef struct packed {
    logic in_ready;
    logic check;
    logic emit_data;
    logic emit_status;
  } ctrl_t;

  typedef struct packed {
    logic stop_taken;
    logic skip_data;
    logic last_data;
    logic out_free;
  } flags_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_e cond;
    step_t tgt;
    step_t alt;
  } uword_t;

  function automatic uword_t ucode(step_t step);
    uword_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.ctrl.in_ready = 1'b1;
        w.cond = COND_STOP;
        w.tgt  = STEP_CHECK;
        w.alt  = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.ctrl.check = 1'b1;
        w.cond = COND_SKIP;
        w.tgt  = STEP_STATUS;
        w.alt  = STEP_DATA;
      end
      STEP_DATA: begin
        w.ctrl.emit_data = 1'b1;
        w.cond = COND_LAST;
        w.tgt  = STEP_STATUS;
        w.alt  = STEP_DATA;
      end
      STEP_STATUS: begin
        w.ctrl.emit_status = 1'b1;
        w.cond = COND_FREE;
        w.tgt  = STEP_IDLE;
        w.alt  = STEP_STATUS;
      end
      default: begin
        w.cond = COND_FREE;
        w.tgt  = STEP_IDLE;
        w.alt  = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/sfc_ram.sv
module sfc_ram
  #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
  ) (
    input  logic             clk_i,
    input  logic             we_i,
    input  logic [AW-1:0]    waddr_i,
    input  logic [WIDTH-1:0] wdata_i,
    input  logic [AW-1:0]    raddr_i,
    output logic [WIDTH-1:0] rdata_o
  );

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sfc_seq.sv
module sfc_seq
  import sfc_pkg::*;
  (
    input  logic   clk_i,
    input  logic   rst_ni,
    input  flags_t flags_i,
    output ctrl_t  ctrl_o
  );

  step_t  pc_q, pc_d;
  uword_t uw;
  logic   take;

  assign uw     = ucode(pc_q);
  assign ctrl_o = uw.ctrl;

  always_comb begin
    case (uw.cond)
      COND_STOP: take = flags_i.stop_taken;
      COND_SKIP: take = flags_i.skip_data;
      COND_LAST: take = flags_i.last_data;
      COND_FREE: take = flags_i.out_free;
      default:   take = 1'b0;
    endcase
    pc_d = take ? uw.tgt : uw.alt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: design/sfc_dp.sv
module sfc_dp
  import sfc_pkg::*;
  #(
    parameter int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
    parameter int unsigned SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
  ) (
    input  logic                clk_i,
    input  logic                rst_ni,
    input  ctrl_t               ctrl_i,
    output flags_t              flags_o,
    input  logic                cfg_we_i,
    input  logic [DB_BITS-1:0]  cfg_wdata_i,
    input  logic                in_valid_i,
    input  logic [SYM_BITS-1:0] symbol_i,
    input  logic                out_stall_i,
    output logic                out_valid_o,
    output logic [SYM_BITS-1:0] data_symbol_o,
    output logic                is_data_o,
    output logic [2:0]          status_o,
    output logic                last_o
  );

  localparam int unsigned SW = SYMBOL_WIDTH;
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned NW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_PAYLOAD);

  logic [DB_BITS-1:0]  data_bits_q;
  logic                in_frame_q;
  logic [CNT_BITS-1:0] count_q;
  logic [SW-1:0]       len_q, acc_q, prev_q;
  logic                ovf_q;
  status_e             err_q, err_d;
  logic [NW-1:0]       ndata_q, idx_q;

  logic                out_valid_q;
  logic [SW-1:0]       out_sym_q;
  logic                out_is_data_q;
  status_e             out_status_q;
  logic                out_last_q;

  logic [SW-1:0]       sym;
  logic [ID_BITS-1:0]  start_id, stop_id, pmask, len_p2;
  logic                is_start, is_stop, accept, out_free, advance;
  logic [CNT_BITS-1:0] store_idx;
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [SW-1:0]       ram_rdata;

  assign sym      = symbol_i[SW-1:0];
  assign start_id = ID_BITS'(1) << data_bits_q;
  assign stop_id  = start_id + ID_BITS'(1);
  assign pmask    = start_id - ID_BITS'(1);
  assign is_start = ID_BITS'(sym) == start_id;
  assign is_stop  = ID_BITS'(sym) == stop_id;
  assign accept   = ctrl_i.in_ready && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = ctrl_i.emit_data && out_free;

  assign store_idx = count_q - CNT_BITS'(2);
  assign ram_we    = accept && !is_start && !is_stop && in_frame_q &&
                     (count_q >= CNT_BITS'(2)) && (store_idx < MAX_CNT);
  assign len_p2    = ID_BITS'(len_q) + ID_BITS'(2);

  always_comb begin
    if (!in_frame_q) begin
      err_d = ST_NO_START;
    end else if (ovf_q) begin
      err_d = ST_OVERFLOW;
    end else if (count_q < CNT_BITS'(2) || ID_BITS'(count_q) != len_p2) begin
      err_d = ST_LENGTH;
    end else if (((ID_BITS'(acc_q ^ prev_q)) & pmask) != ID_BITS'(prev_q)) begin
      err_d = ST_PARITY;
    end else begin
      err_d = ST_OK;
    end
  end

  always_comb begin
    if (ctrl_i.check) begin
      ram_raddr = '0;
    end else if (advance) begin
      ram_raddr = AW'(idx_q + NW'(1));
    end else begin
      ram_raddr = AW'(idx_q);
    end
  end

  assign flags_o.stop_taken = accept && is_stop && !is_start;
  assign flags_o.skip_data  = (err_d != ST_OK) || (count_q == CNT_BITS'(2));
  assign flags_o.last_data  = out_free &&
                              ({1'b0, idx_q} + (NW + 1)'(1) == {1'b0, ndata_q});
  assign flags_o.out_free   = out_free;

  sfc_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(store_idx)),
    .wdata_i(prev_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= DATA_BITS_RST;
      in_frame_q  <= 1'b0;
      count_q     <= '0;
      len_q       <= '0;
      acc_q       <= '0;
      prev_q      <= '0;
      ovf_q       <= 1'b0;
      err_q       <= ST_OK;
      ndata_q     <= '0;
      idx_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        data_bits_q <= cfg_wdata_i;
      end
      if (accept && is_start) begin
        in_frame_q <= 1'b1;
        count_q    <= '0;
        len_q      <= '0;
        acc_q      <= '0;
        prev_q     <= '0;
        ovf_q      <= 1'b0;
      end else if (accept && !is_stop && in_frame_q) begin
        if (count_q == '0) begin
          len_q <= sym;
        end else begin
          if (count_q >= CNT_BITS'(2) && store_idx >= MAX_CNT) begin
            ovf_q <= 1'b1;
          end
          acc_q  <= acc_q ^ sym;
          prev_q <= sym;
        end
        if (count_q < COUNT_MAX) begin
          count_q <= count_q + CNT_BITS'(1);
        end
      end
      if (ctrl_i.check) begin
        in_frame_q <= 1'b0;
        err_q      <= err_d;
        ndata_q    <= NW'(store_idx);
        idx_q      <= '0;
      end else if (advance) begin
        idx_q <= idx_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ctrl_i.emit_data || ctrl_i.emit_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (ctrl_i.emit_data) begin
        out_sym_q     <= ram_rdata;
        out_is_data_q <= 1'b1;
        out_status_q  <= ST_OK;
        out_last_q    <= 1'b0;
      end else if (ctrl_i.emit_status) begin
        out_sym_q     <= '0;
        out_is_data_q <= 1'b0;
        out_status_q  <= err_q;
        out_last_q    <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_symbol_o = SYM_BITS'(out_sym_q);
  assign is_data_o     = out_is_data_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

endmodule

FILE: design/symbol_frame_checker.sv
// Symbol frame checker: deframes start, length, data..., parity, stop.
// Input channel: symbol_i with in_valid_i / in_stall_o; a transfer happens
// on a clock edge with valid high and stall low. Output channel: one item
// per transfer (data_symbol_o, is_data_o, status_o, last_o) with
// out_valid_o / out_stall_i, held steady while stalled.
// cfg_we_i writes data_bits from cfg_wdata_i; write only while idle.
// Start, length, data and parity symbols are accepted back to back. A stop
// symbol runs a microcode routine: idle accepts it, check checks the frame,
// data emits the payload items and status emits the status item, and the
// next symbol is taken no earlier than the return to idle. Payload
// is read from the buffer RAM one entry per cycle; the output register lets
// the sequencer run ahead by one item. A stalled output holds the sequencer
// in its emit step; the input is stalled until the run ends.
// Reset: outside any frame, data_bits = 8, output empty. Buffer contents
// need no clearing; only entries written in the current frame are read.
module symbol_frame_checker
  import sfc_pkg::*;
  #(
    parameter int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
    parameter int unsigned SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
  ) (
    input  logic                clk_i,
    input  logic                rst_ni,
    input  logic                cfg_we_i,
    input  logic [DB_BITS-1:0]  cfg_wdata_i,
    input  logic                in_valid_i,
    output logic                in_stall_o,
    input  logic [SYM_BITS-1:0] symbol_i,
    output logic                out_valid_o,
    input  logic                out_stall_i,
    output logic [SYM_BITS-1:0] data_symbol_o,
    output logic                is_data_o,
    output logic [2:0]          status_o,
    output logic                last_o
  );

  ctrl_t  ctrl;
  flags_t flags;

  assign in_stall_o = !ctrl.in_ready;

  sfc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  sfc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .SYMBOL_WIDTH(SYMBOL_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .symbol_i     (symbol_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .data_symbol_o(data_symbol_o),
    .is_data_o    (is_data_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

FILE: dv/sfc_deframe_checker.sv
`timescale 1ns / 1ps

module sfc_deframe_checker
  import sfc_pkg::*;
  (
    input  logic                clk_i,
    input  logic                rst_ni,
    input  logic                cfg_we_i,
    input  logic [DB_BITS-1:0]  cfg_wdata_i,
    input  logic                in_valid_i,
    input  logic                in_stall_i,
    input  logic [SYM_BITS-1:0] symbol_i,
    input  logic                out_valid_i,
    input  logic                out_stall_i,
    input  logic [SYM_BITS-1:0] data_symbol_i,
    input  logic                is_data_i,
    input  logic [2:0]          status_i,
    input  logic                last_i,
    output int                  fail_count_o,
    output int                  pending_o
  );

  localparam int unsigned RING_DEPTH = 256;

  typedef struct packed {
    logic [SYM_BITS-1:0] data_symbol;
    logic                is_data;
    status_e             status;
    logic                last;
  } deframed_t;

  deframed_t   awaited_items [RING_DEPTH];
  logic [7:0]  ring_head;
  logic [7:0]  ring_tail;
  int unsigned ring_used;

  logic [DB_BITS-1:0]  data_bits;
  logic                in_frame;
  logic [CNT_BITS-1:0] symbol_count;
  logic [SYM_BITS-1:0] length_field;
  logic [SYM_BITS-1:0] parity_acc;
  logic [SYM_BITS-1:0] prev_symbol;
  logic                overflowed;
  logic [SYM_BITS-1:0] payload_store [MAX_PAYLOAD_DEF];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    ring_head    = '0;
    ring_tail    = '0;
    ring_used    = 0;
  end

  function automatic void push_item(logic [SYM_BITS-1:0] sym, logic data, status_e st);
    deframed_t it;
    it.data_symbol = sym;
    it.is_data     = data;
    it.status      = st;
    it.last        = !data;
    if (ring_used >= RING_DEPTH) begin
      fail_count_o++;
      $display("%0t: expected items overrun the checker ring", $time);
    end else begin
      awaited_items[ring_tail] = it;
      ring_tail = ring_tail + 8'd1;
      ring_used++;
    end
  endfunction

  function automatic void deframe_step(logic [SYM_BITS-1:0] s);
    logic [ID_BITS-1:0]  start_id;
    logic [ID_BITS-1:0]  stop_id;
    logic [SYM_BITS-1:0] pmask;
    int unsigned         ndata;
    int unsigned         idx;
    start_id = 17'd1 << data_bits;
    stop_id  = start_id + 17'd1;
    pmask    = SYM_BITS'(start_id - 17'd1);
    if ({1'b0, s} == start_id) begin
      in_frame     = 1'b1;
      symbol_count = '0;
      length_field = '0;
      parity_acc   = '0;
      prev_symbol  = '0;
      overflowed   = 1'b0;
    end else if ({1'b0, s} == stop_id) begin
      if (!in_frame) begin
        push_item('0, 1'b0, ST_NO_START);
      end else begin
        in_frame = 1'b0;
        if (overflowed) begin
          push_item('0, 1'b0, ST_OVERFLOW);
        end else if (symbol_count < 2 ||
                     int'(symbol_count) != int'(length_field) + 2) begin
          push_item('0, 1'b0, ST_LENGTH);
        end else if (((parity_acc ^ prev_symbol) & pmask) != prev_symbol) begin
          push_item('0, 1'b0, ST_PARITY);
        end else begin
          ndata = symbol_count - 2;
          for (int unsigned i = 0; i < ndata && i < MAX_PAYLOAD_DEF; i++) begin
            push_item(payload_store[i], 1'b1, ST_OK);
          end
          push_item('0, 1'b0, ST_OK);
        end
      end
    end else if (in_frame) begin
      if (symbol_count == 0) begin
        length_field = s;
      end else begin
        // previous symbol turns out to be payload once another follows it
        if (symbol_count >= 2) begin
          idx = symbol_count - 2;
          if (idx < MAX_PAYLOAD_DEF) begin
            payload_store[idx] = prev_symbol;
          end else begin
            overflowed = 1'b1;
          end
        end
        parity_acc  = parity_acc ^ s;
        prev_symbol = s;
      end
      if (symbol_count < COUNT_MAX) begin
        symbol_count = symbol_count + 1'b1;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deframed_t got;
    deframed_t want;
    if (!rst_ni) begin
      data_bits    = DATA_BITS_RST;
      in_frame     = 1'b0;
      symbol_count = '0;
      length_field = '0;
      parity_acc   = '0;
      prev_symbol  = '0;
      overflowed   = 1'b0;
      ring_head    = '0;
      ring_tail    = '0;
      ring_used    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.data_symbol = data_symbol_i;
        got.is_data     = is_data_i;
        got.status      = status_e'(status_i);
        got.last        = last_i;
        if (ring_used == 0) begin
          fail_count_o++;
          $display("%0t: unexpected transfer: data_symbol=%h is_data=%b status=%0d last=%b",
                   $time, data_symbol_i, is_data_i, status_i, last_i);
        end else begin
          want      = awaited_items[ring_head];
          ring_head = ring_head + 8'd1;
          ring_used--;
          if (got !== want) begin
            fail_count_o++;
            $display("%0t: mismatch: expected data_symbol=%h is_data=%b status=%0d last=%b",
                     $time, want.data_symbol, want.is_data, want.status, want.last);
            $display("%0t:           actual   data_symbol=%h is_data=%b status=%0d last=%b",
                     $time, data_symbol_i, is_data_i, status_i, last_i);
          end
        end
      end
      if (cfg_we_i) begin
        data_bits = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        deframe_step(symbol_i);
      end
    end
    pending_o = ring_used;
  end

endmodule

FILE: dv/tb_symbol_frame_checker.sv
`timescale 1ns / 1ps

module tb_symbol_frame_checker;
  import sfc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned NUM_PHASES    = 7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [DB_BITS-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic [SYM_BITS-1:0] symbol_i    = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [SYM_BITS-1:0] data_symbol_o;
  logic                is_data_o;
  logic [2:0]          status_o;
  logic                last_o;

  int                  fail_count;
  int                  pending;
  logic [DB_BITS-1:0]  db          = DATA_BITS_RST;
  bit                  src_steady  = 1'b0;
  bit                  sink_steady = 1'b0;
  int unsigned         stall_left  = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         symbols_sent = 0;

  symbol_frame_checker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .symbol_i      (symbol_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_symbol_o (data_symbol_o),
    .is_data_o     (is_data_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  sfc_deframe_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .symbol_i      (symbol_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_symbol_i (data_symbol_o),
    .is_data_i     (is_data_o),
    .status_i      (status_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [SYM_BITS-1:0] start_sym();
    return SYM_BITS'(17'd1 << db);
  endfunction

  function automatic logic [SYM_BITS-1:0] stop_sym();
    return SYM_BITS'((17'd1 << db) + 17'd1);
  endfunction

  function automatic bit is_marker(logic [SYM_BITS-1:0] s);
    return s == start_sym() || s == stop_sym();
  endfunction

  function automatic logic [SYM_BITS-1:0] rand_payload();
    logic [SYM_BITS-1:0] s;
    s = SYM_BITS'($urandom_range(0, 65535));
    while (is_marker(s)) s = SYM_BITS'($urandom_range(0, 65535));
    return s;
  endfunction

  // sink side: random stall runs unless in a steady stretch
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!sink_steady && $urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called and returns at a falling edge
  task automatic send_symbol(input logic [SYM_BITS-1:0] s, input bit counted);
    int unsigned gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (counted) symbols_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_data_bits(input logic [DB_BITS-1:0] v);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    db = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned n_data, input bit bad_len, input bit bad_par);
    logic [SYM_BITS-1:0] len_sym;
    logic [SYM_BITS-1:0] xsum;
    logic [SYM_BITS-1:0] par;
    logic [SYM_BITS-1:0] d;
    xsum = '0;
    send_symbol(start_sym(), 1'b1);
    if (!bad_len) begin
      len_sym = SYM_BITS'(n_data);
    end else if ($urandom_range(0, 1) == 0) begin
      len_sym = SYM_BITS'(n_data + $urandom_range(1, 2));
    end else begin
      len_sym = SYM_BITS'($urandom_range(0, 65535));
    end
    while (is_marker(len_sym)) len_sym = SYM_BITS'($urandom_range(0, 65535));
    send_symbol(len_sym, 1'b1);
    for (int unsigned i = 0; i < n_data; i++) begin
      d = rand_payload();
      xsum = xsum ^ d;
      send_symbol(d, 1'b1);
    end
    par = xsum & (start_sym() - 1'b1);
    if (bad_par) begin
      d = par;
      do begin
        par = d ^ (16'd1 << $urandom_range(0, 15));
      end while (is_marker(par));
    end
    send_symbol(par, 1'b1);
    send_symbol(stop_sym(), 1'b1);
  endtask

  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    logic [DB_BITS-1:0] plan [NUM_PHASES];
    plan[0] = 4'd15;
    plan[1] = 4'd0;
    plan[2] = 4'd1;
    for (int i = 3; i < NUM_PHASES; i++) plan[i] = DB_BITS'($urandom_range(0, 15));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset setting: start 256, stop 257
    send_symbol(stop_sym(), 1'b1);
    send_symbol(16'hFFFF, 1'b0);
    send_symbol(16'h0000, 1'b0);
    send_symbol(start_sym(), 1'b1);
    send_symbol(16'd2, 1'b1);
    send_symbol(16'hFFFF, 1'b1);
    send_symbol(16'h0000, 1'b1);
    send_symbol(16'h00FF, 1'b1);
    send_symbol(stop_sym(), 1'b1);
    send_symbol(start_sym(), 1'b1);
    send_symbol(stop_sym(), 1'b1);
    send_symbol(start_sym(), 1'b1);
    send_symbol(16'd5, 1'b1);
    send_symbol(start_sym(), 1'b1);
    send_symbol(16'd0, 1'b1);
    send_symbol(16'd0, 1'b1);
    send_symbol(stop_sym(), 1'b1);
    send_symbol(start_sym(), 1'b1);
    send_symbol(16'd1, 1'b1);
    send_symbol(16'h0012, 1'b1);
    send_symbol(16'h0013, 1'b1);
    send_symbol(stop_sym(), 1'b1);
    send_symbol(start_sym(), 1'b1);
    send_symbol(16'd3, 1'b1);
    send_symbol(16'd1, 1'b1);
    send_symbol(16'd1, 1'b1);
    send_symbol(stop_sym(), 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_data_bits(plan[p]);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        send_frame(MAX_PAYLOAD_DEF, 1'b0, 1'b0);
        send_frame(MAX_PAYLOAD_DEF + 2, 1'b0, 1'b0);
      end
      if (p == 1) send_frame(128, 1'b0, 1'b0);
      target = symbols_sent + PHASE_ITEMS;
      while (symbols_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          n = $urandom_range(0, 99);
          if (n < 60) n = $urandom_range(0, 4);
          else if (n < 90) n = $urandom_range(5, 12);
          else n = $urandom_range(13, MAX_PAYLOAD_DEF);
          send_frame(n, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15);
        end else if (pick < 78) begin
          send_symbol(SYM_BITS'($urandom_range(0, 65535)), 1'b0);
        end else if (pick < 84) begin
          send_symbol(stop_sym(), 1'b1);
        end else if (pick < 90) begin
          send_symbol(start_sym(), 1'b1);
          repeat ($urandom_range(0, 4)) send_symbol(rand_payload(), 1'b1);
        end else if (pick < 94) begin
          wait_results_drained();
        end else begin
          send_frame($urandom_range(MAX_PAYLOAD_DEF + 1, MAX_PAYLOAD_DEF + 8),
                     1'b0, 1'($urandom_range(0, 1)));
        end
      end
    end

    wait_results_drained();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: symbol_frame_checker.f
design/sfc_pkg.sv
design/sfc_ram.sv
design/sfc_seq.sv
design/sfc_dp.sv
design/symbol_frame_checker.sv
dv/sfc_deframe_checker.sv
dv/tb_symbol_frame_checker.sv
